// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== rtl/i2cseq_pkg.sv =====
`timescale 1ns / 1ps

package i2cseq_pkg;

   // Request operations
   localparam logic [1:0] OP_PTR_RESET = 2'd0;
   localparam logic [1:0] OP_READ      = 2'd1;
   localparam logic [1:0] OP_WRITE     = 2'd2;

   // Register indexes
   localparam logic CSR_EEPROM_TYPE = 1'b0;
   localparam logic CSR_DEVICE_BASE = 1'b1;

   // Device types
   localparam logic [2:0] TYPE_1K  = 3'd0;
   localparam logic [2:0] TYPE_2K  = 3'd1;
   localparam logic [2:0] TYPE_4K  = 3'd2;
   localparam logic [2:0] TYPE_8K  = 3'd3;
   localparam logic [2:0] TYPE_16K = 3'd4;
   localparam logic [2:0] TYPE_32K = 3'd5;

   localparam logic [6:0]  DEVICE_BASE_RESET = 7'h50;
   localparam logic [15:0] MASK_A8  = 16'h0100;
   localparam logic [15:0] MASK_A9  = 16'h0300;
   localparam logic [15:0] MASK_A10 = 16'h0700;
   localparam logic [7:0]  BYTE_MASK = 8'hFF;

   localparam int CNT_W = 6;

   typedef enum logic [1:0] {
      KIND_ADDR_HI,
      KIND_ADDR_LO,
      KIND_DATA,
      KIND_READ_REQ
   } item_kind_type;

   typedef struct packed {
      logic          emit;
      item_kind_type kind;
      logic          first;
      logic          stop;
      logic          last;
      logic          ptr_clear;
      logic          store_byte;
      logic          start_write;
      logic          load_chunk;
   } ctrl_cmd_type;

   typedef struct packed {
      logic slot_free;
      logic two_byte;
      logic fill_last;
      logic chunk_last;
      logic block_last;
   } dp_status_type;

endpackage

// ===== rtl/i2cseq_dp.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2cseq_dp #(
   parameter int BLOCK_BYTES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [7:0]                        req_data,
   input  logic                              csr_write_enable,
   input  logic                              csr_index,
   input  logic [6:0]                        csr_write_data,
   input  i2cseq_pkg::ctrl_cmd_type          cmd,
   output i2cseq_pkg::dp_status_type         status,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [6:0]                        rsp_bus_address,
   output logic                              rsp_direction,
   output logic [7:0]                        rsp_payload,
   output logic [i2cseq_pkg::CNT_W-1:0]      rsp_read_count,
   output logic                              rsp_first_of_transaction,
   output logic                              rsp_stop_after,
   output logic                              rsp_last
);

   localparam int IDX_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
   localparam int CW = i2cseq_pkg::CNT_W;
   localparam logic [CW-1:0] BLOCK_CNT = CW'(BLOCK_BYTES);
   localparam logic [CW-1:0] FILL_LAST = CW'(BLOCK_BYTES - 1);
   localparam logic [15:0]   PTR_STEP  = 16'(BLOCK_BYTES);

   logic [2:0]       eeprom_type_ff;
   logic [6:0]       device_base_ff;
   logic [15:0]      ptr_ff;
   logic [CW-1:0]    fill_ff;
   logic [CW-1:0]    left_ff;
   logic [CW-1:0]    chunk_left_ff;
   logic [IDX_W-1:0] byte_idx_ff;
   logic [IDX_W-1:0] byte_idx_in;
   logic [7:0]       block_mem [BLOCK_BYTES];
   logic [7:0]       mem_q_ff;

   logic             rsp_valid_ff;
   logic [6:0]       rsp_bus_address_ff;
   logic             rsp_direction_ff;
   logic [7:0]       rsp_payload_ff;
   logic [CW-1:0]    rsp_read_count_ff;
   logic             rsp_first_ff;
   logic             rsp_stop_ff;
   logic             rsp_last_ff;

   logic [CW-1:0]    page_room;
   logic [CW-1:0]    chunk;
   logic [15:0]      hi_masked;
   logic [6:0]       bus_addr;
   logic [7:0]       item_payload;
   logic             data_emit;

   assign data_emit = cmd.emit && (cmd.kind == i2cseq_pkg::KIND_DATA);

   // Bytes left before the current page boundary.
   always_comb begin
      case (eeprom_type_ff) inside
         i2cseq_pkg::TYPE_1K, i2cseq_pkg::TYPE_2K:
            page_room = CW'(8) - {3'b000, ptr_ff[2:0]};
         i2cseq_pkg::TYPE_4K, i2cseq_pkg::TYPE_8K, i2cseq_pkg::TYPE_16K:
            page_room = CW'(16) - {2'b00, ptr_ff[3:0]};
         default:
            page_room = CW'(32) - {1'b0, ptr_ff[4:0]};
      endcase
   end

   assign chunk = (page_room < left_ff) ? page_room : left_ff;

   // High memory address bits ride in the device address on small parts.
   always_comb begin
      case (eeprom_type_ff)
         i2cseq_pkg::TYPE_4K:  hi_masked = ptr_ff & i2cseq_pkg::MASK_A8;
         i2cseq_pkg::TYPE_8K:  hi_masked = ptr_ff & i2cseq_pkg::MASK_A9;
         i2cseq_pkg::TYPE_16K: hi_masked = ptr_ff & i2cseq_pkg::MASK_A10;
         default:              hi_masked = 16'h0000;
      endcase
   end

   assign bus_addr = device_base_ff | hi_masked[14:8];

   always_comb begin
      case (cmd.kind)
         i2cseq_pkg::KIND_ADDR_HI: item_payload = ptr_ff[15:8];
         i2cseq_pkg::KIND_ADDR_LO: item_payload = ptr_ff[7:0] & i2cseq_pkg::BYTE_MASK;
         i2cseq_pkg::KIND_DATA:    item_payload = mem_q_ff;
         default:                  item_payload = 8'h00;
      endcase
   end

   always_comb begin
      byte_idx_in = byte_idx_ff;
      if (cmd.start_write) begin
         byte_idx_in = '0;
      end else if (data_emit && !status.block_last) begin
         byte_idx_in = byte_idx_ff + IDX_W'(1);
      end
   end

   always_comb begin
      status.slot_free  = !rsp_valid_ff || rsp_ready;
      status.two_byte   = eeprom_type_ff >= i2cseq_pkg::TYPE_32K;
      status.fill_last  = fill_ff >= FILL_LAST;
      status.chunk_last = chunk_left_ff == CW'(1);
      status.block_last = left_ff == CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eeprom_type_ff <= i2cseq_pkg::TYPE_1K;
         device_base_ff <= i2cseq_pkg::DEVICE_BASE_RESET;
         ptr_ff         <= '0;
         fill_ff        <= '0;
         left_ff        <= '0;
         chunk_left_ff  <= '0;
         byte_idx_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == i2cseq_pkg::CSR_EEPROM_TYPE) begin
               eeprom_type_ff <= csr_write_data[2:0];
            end else begin
               device_base_ff <= csr_write_data;
            end
         end

         if (cmd.ptr_clear) begin
            ptr_ff <= '0;
         end else if (data_emit) begin
            ptr_ff <= ptr_ff + 16'd1;
         end else if (cmd.emit && cmd.kind == i2cseq_pkg::KIND_READ_REQ) begin
            ptr_ff <= ptr_ff + PTR_STEP;
         end

         if (cmd.start_write) begin
            fill_ff <= '0;
         end else if (cmd.store_byte) begin
            fill_ff <= fill_ff + CW'(1);
         end

         if (cmd.start_write) begin
            left_ff <= BLOCK_CNT;
         end else if (data_emit) begin
            left_ff <= left_ff - CW'(1);
         end

         if (cmd.emit && cmd.load_chunk) begin
            chunk_left_ff <= chunk;
         end else if (data_emit) begin
            chunk_left_ff <= chunk_left_ff - CW'(1);
         end

         byte_idx_ff <= byte_idx_in;

         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Block buffer: read ahead at the next index so the byte is ready on emit.
   always_ff @(posedge clock) begin
      if (cmd.store_byte) begin
         block_mem[fill_ff[IDX_W-1:0]] <= req_data;
      end
      mem_q_ff <= block_mem[byte_idx_in];
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_bus_address_ff <= bus_addr;
         rsp_direction_ff   <= cmd.kind == i2cseq_pkg::KIND_READ_REQ;
         rsp_payload_ff     <= item_payload;
         rsp_read_count_ff  <= (cmd.kind == i2cseq_pkg::KIND_READ_REQ) ? BLOCK_CNT : '0;
         rsp_first_ff       <= cmd.first;
         rsp_stop_ff        <= cmd.stop;
         rsp_last_ff        <= cmd.last;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_bus_address          = rsp_bus_address_ff;
   assign rsp_direction            = rsp_direction_ff;
   assign rsp_payload              = rsp_payload_ff;
   assign rsp_read_count           = rsp_read_count_ff;
   assign rsp_first_of_transaction = rsp_first_ff;
   assign rsp_stop_after           = rsp_stop_ff;
   assign rsp_last                 = rsp_last_ff;

   `ASSERT_IMPL(a_fill_in_range, 1'b1, fill_ff < BLOCK_CNT, "fill count reached block size")
   `ASSERT_IMPL(a_chunk_nonempty, data_emit, chunk_left_ff != '0, "data byte outside a chunk")
   `ASSERT_IMPL(a_block_nonempty, data_emit, left_ff != '0, "data byte past end of block")

endmodule

// ===== rtl/i2cseq_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2cseq_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_operation,
   input  i2cseq_pkg::dp_status_type  status,
   output i2cseq_pkg::ctrl_cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADDR_HI,
      ST_ADDR_LO,
      ST_DATA,
      ST_READ_REQ
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      write_mode_ff;
   logic      write_mode_in;
   logic      accept;
   state_type addr_start;

   assign req_ready  = state_ff == ST_IDLE;
   assign accept     = req_valid && req_ready;
   assign addr_start = status.two_byte ? ST_ADDR_HI : ST_ADDR_LO;

   always_comb begin
      state_in         = state_ff;
      write_mode_in    = write_mode_ff;
      cmd.emit         = 1'b0;
      cmd.kind         = i2cseq_pkg::KIND_DATA;
      cmd.first        = 1'b0;
      cmd.stop         = 1'b0;
      cmd.last         = 1'b0;
      cmd.ptr_clear    = 1'b0;
      cmd.store_byte   = 1'b0;
      cmd.start_write  = 1'b0;
      cmd.load_chunk   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_operation)
                  i2cseq_pkg::OP_PTR_RESET: begin
                     cmd.ptr_clear = 1'b1;
                  end
                  i2cseq_pkg::OP_READ: begin
                     write_mode_in = 1'b0;
                     state_in      = addr_start;
                  end
                  i2cseq_pkg::OP_WRITE: begin
                     cmd.store_byte = 1'b1;
                     // The byte that fills the block launches the page writes.
                     if (status.fill_last) begin
                        cmd.start_write = 1'b1;
                        write_mode_in   = 1'b1;
                        state_in        = addr_start;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_ADDR_HI: begin
            if (status.slot_free) begin
               cmd.emit  = 1'b1;
               cmd.kind  = i2cseq_pkg::KIND_ADDR_HI;
               cmd.first = 1'b1;
               state_in  = ST_ADDR_LO;
            end
         end
         ST_ADDR_LO: begin
            if (status.slot_free) begin
               cmd.emit       = 1'b1;
               cmd.kind       = i2cseq_pkg::KIND_ADDR_LO;
               cmd.first      = !status.two_byte;
               cmd.load_chunk = write_mode_ff;
               state_in       = write_mode_ff ? ST_DATA : ST_READ_REQ;
            end
         end
         ST_DATA: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.kind = i2cseq_pkg::KIND_DATA;
               cmd.stop = status.chunk_last;
               cmd.last = status.chunk_last && status.block_last;
               if (status.chunk_last) begin
                  state_in = status.block_last ? ST_IDLE : addr_start;
               end
            end
         end
         ST_READ_REQ: begin
            if (status.slot_free) begin
               cmd.emit  = 1'b1;
               cmd.kind  = i2cseq_pkg::KIND_READ_REQ;
               cmd.first = 1'b1;
               cmd.stop  = 1'b1;
               cmd.last  = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         write_mode_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         write_mode_ff <= write_mode_in;
      end
   end

   `ASSERT_IMPL(a_emit_needs_slot, cmd.emit, status.slot_free, "item issued into a full output")
   `ASSERT_IMPL(a_last_has_stop, cmd.emit && cmd.last, cmd.stop, "final item without stop")
   `ASSERT_NEXT(a_read_ends_idle, cmd.emit && cmd.kind == i2cseq_pkg::KIND_READ_REQ, req_ready, "read request did not return to idle")

endmodule

// ===== rtl/i2c_eeprom_transfer_sequencer_core.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Content
// req_      in         req_valid/req_ready    operation, data byte
// rsp_      out        rsp_valid/rsp_ready    one bus item per transfer
// csr_      in         csr_write_enable       eeprom_type (0), device_base (1)
//
// A pointer reset, an unused operation or a byte that leaves the block short
// keeps the core idle. A read gives 2 or 3 items, one per cycle; a full block
// gives BLOCK_BYTES data items plus one or two address items per page chunk,
// one per cycle, from a single state machine stepping through the block buffer.
// A new request is taken once the last item has gone into the output register.
// A low rsp_ready holds the sequencer on the current item. Reset is synchronous.

module i2c_eeprom_transfer_sequencer_core #(
   parameter int BLOCK_BYTES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_operation,
   input  logic [7:0]                    req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [6:0]                    rsp_bus_address,
   output logic                          rsp_direction,
   output logic [7:0]                    rsp_payload,
   output logic [i2cseq_pkg::CNT_W-1:0]  rsp_read_count,
   output logic                          rsp_first_of_transaction,
   output logic                          rsp_stop_after,
   output logic                          rsp_last,
   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [6:0]                    csr_write_data
);

   i2cseq_pkg::ctrl_cmd_type  cmd;
   i2cseq_pkg::dp_status_type status;

   i2cseq_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd)
   );

   i2cseq_dp #(
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_dp (
      .clock                    (clock),
      .reset                    (reset),
      .req_data                 (req_data),
      .csr_write_enable         (csr_write_enable),
      .csr_index                (csr_index),
      .csr_write_data           (csr_write_data),
      .cmd                      (cmd),
      .status                   (status),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_bus_address          (rsp_bus_address),
      .rsp_direction            (rsp_direction),
      .rsp_payload              (rsp_payload),
      .rsp_read_count           (rsp_read_count),
      .rsp_first_of_transaction (rsp_first_of_transaction),
      .rsp_stop_after           (rsp_stop_after),
      .rsp_last                 (rsp_last)
   );

endmodule
